FILE: rtl/wnm_pkg.sv
// Shared types and constants for the wildcard name matcher.
// No dependencies; every module of the block imports this package.
package wnm_pkg;

    localparam int PATTERN_MAX_DEF = 64;
    localparam int CHAR_W          = 8;
    localparam int CMD_W           = 2;

    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
    localparam logic [CMD_W-1:0] CMD_NAME   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd3;

    localparam logic [CHAR_W-1:0] STAR_CHAR = 8'd42;
    localparam logic [CHAR_W-1:0] ANY_CHAR  = 8'd63;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [CHAR_W-1:0] char_value;
        logic              last;
    } t_in_word;

    typedef struct packed {
        logic matched;
        logic pattern_overflow;
    } t_out_word;

    // Broadcast control to every cell of the row
    typedef struct packed {
        logic              clear;
        logic              append;
        logic              step;
        logic              fresh;
        logic [CHAR_W-1:0] ch;
    } t_cell_ctl;

endpackage

FILE: rtl/wnm_cell.sv
// One pattern position: stored character, fill bit, start-set bit and active bit.
// Depends on wnm_pkg; instantiated in a row by the top level.
module wnm_cell import wnm_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  logic      i_seed,
    input  logic      i_fill,
    input  logic      i_start_ext,
    input  logic      i_act_next,
    output logic      o_used,
    output logic      o_star,
    output logic      o_stay,
    output logic      o_fwd,
    output logic      o_start_ext,
    output logic      o_start
);

    logic [CHAR_W-1:0] r_char;
    logic [CHAR_W-1:0] n_char;
    logic              r_used;
    logic              n_used;
    logic              r_start;
    logic              n_start;
    logic              r_act;
    logic              n_act;
    logic              start_bit;
    logic              cur;
    logic              is_star;
    logic              hit;
    logic              wr;

    assign wr        = i_ctl.append & i_fill;
    assign start_bit = r_start | i_seed;
    assign cur       = i_ctl.fresh ? start_bit : r_act;
    assign is_star   = r_used & (r_char == STAR_CHAR);
    assign hit       = r_used & ~is_star & ((r_char == ANY_CHAR) | (r_char == i_ctl.ch));

    // a star keeps its own position; any other hit hands the bit to the next cell
    assign o_stay      = cur & is_star;
    assign o_fwd       = cur & hit;
    assign o_star      = is_star;
    assign o_used      = r_used;
    assign o_start     = start_bit;
    assign o_start_ext = wr & (i_ctl.ch == STAR_CHAR) & start_bit;

    always_comb begin
        n_char  = wr ? i_ctl.ch : r_char;
        n_used  = r_used;
        n_start = r_start;
        n_act   = i_ctl.step ? i_act_next : r_act;
        if (i_ctl.clear) begin
            n_used  = 1'b0;
            n_start = 1'b0;
        end else begin
            n_used  = r_used | wr;
            n_start = r_start | i_start_ext;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used  <= 1'b0;
            r_start <= 1'b0;
            r_act   <= 1'b0;
        end else begin
            r_used  <= n_used;
            r_start <= n_start;
            r_act   <= n_act;
        end
    end

    always_ff @(posedge i_clk) begin
        r_char <= n_char;
    end

endmodule

FILE: rtl/wnm_closure.sv
// Star closure of a position set: a reached star also reaches the position after it.
// Depends on wnm_pkg for the default width; combinational, one carry chain.
module wnm_closure import wnm_pkg::*; #(
    parameter int W = PATTERN_MAX_DEF + 1
) (
    input  logic [W-1:0] i_set,
    input  logic [W-1:0] i_star,
    output logic [W-1:0] o_set
);

    logic [W-1:0] seed;
    logic [W-1:0] sum;
    logic [W-1:0] carries;

    // generate at a reached star, propagate through unreached stars, kill elsewhere
    assign seed    = i_set & i_star;
    assign sum     = i_star + seed;
    assign carries = sum ^ i_star ^ seed;
    assign o_set   = i_set | carries;

endmodule

FILE: rtl/wildcard_name_matcher_unit.sv
// Wildcard name matcher: loads a glob pattern ('*' any run, '?' one character) one
// character per word after a clear, then checks names streamed one character per word.
// One word is accepted every cycle while results drain; once a stalled result has a
// second one waiting behind it in the skid word, the input stalls until the output moves.
// A result for the word that carries last (or the empty-name query) is registered.
// The longest path is the star-closure adder of PATTERN_MAX+1 bits across the row of
// position cells. Characters appended beyond PATTERN_MAX are dropped and raise the
// sticky overflow flag until the next clear.
// Depends on wnm_pkg, wnm_cell and wnm_closure.
module wildcard_name_matcher_unit import wnm_pkg::*; #(
    parameter int PATTERN_MAX = PATTERN_MAX_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word
);

    localparam int NPOS = PATTERN_MAX + 1;

    logic              in_acc;
    logic              is_clear;
    logic              is_append;
    logic              is_name;
    logic              is_query;
    t_cell_ctl         ctl;

    logic [PATTERN_MAX-1:0] used_vec;
    logic [PATTERN_MAX-1:0] star_cells;
    logic [PATTERN_MAX-1:0] stay_vec;
    logic [PATTERN_MAX-1:0] fwd_vec;
    logic [PATTERN_MAX-1:0] start_cells;
    logic [PATTERN_MAX:0]   ext_chain;
    logic [NPOS-1:0]        end_vec;
    logic [NPOS-1:0]        pre_vec;
    logic [NPOS-1:0]        star_vec;
    logic [NPOS-1:0]        closed_vec;
    logic [NPOS-1:0]        start_vec;

    logic      r_busy;
    logic      n_busy;
    logic      r_ovf;
    logic      n_ovf;
    logic      r_start_end;
    logic      n_start_end;
    logic      r_out_valid;
    logic      n_out_valid;
    t_out_word r_out;
    t_out_word n_out;
    logic      r_skid_valid;
    logic      n_skid_valid;
    t_out_word r_skid;
    t_out_word n_skid;

    logic      res_valid;
    t_out_word res;
    logic      out_fire;

    assign o_in_stall = r_skid_valid;
    assign in_acc     = i_in_valid & ~o_in_stall;

    always_comb begin
        is_clear  = 1'b0;
        is_append = 1'b0;
        is_name   = 1'b0;
        is_query  = 1'b0;
        unique case (i_in_word.cmd)
            CMD_CLEAR:  is_clear  = in_acc;
            CMD_APPEND: is_append = in_acc;
            CMD_NAME:   is_name   = in_acc;
            CMD_QUERY:  is_query  = in_acc;
            default:    is_clear  = 1'b0;
        endcase
    end

    assign ctl.clear  = is_clear;
    assign ctl.append = is_append;
    assign ctl.step   = is_name;
    assign ctl.fresh  = ~r_busy;
    assign ctl.ch     = i_in_word.char_value;

    assign ext_chain[0] = 1'b0;

    genvar g;
    generate
        for (g = 0; g < PATTERN_MAX; g++) begin : g_cell
            logic seed;
            assign seed = (g == 0) ? 1'b1 : 1'b0;

            wnm_cell u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_ctl       (ctl),
                .i_seed      (seed),
                .i_fill      (end_vec[g]),
                .i_start_ext (ext_chain[g]),
                .i_act_next  (closed_vec[g]),
                .o_used      (used_vec[g]),
                .o_star      (star_cells[g]),
                .o_stay      (stay_vec[g]),
                .o_fwd       (fwd_vec[g]),
                .o_start_ext (ext_chain[g+1]),
                .o_start     (start_cells[g])
            );

            // one-hot end of pattern and pre-closure next set
            if (g == 0) begin : g_first
                assign end_vec[g] = ~used_vec[g];
                assign pre_vec[g] = stay_vec[g];
            end else begin : g_rest
                assign end_vec[g] = used_vec[g-1] & ~used_vec[g];
                assign pre_vec[g] = stay_vec[g] | fwd_vec[g-1];
            end
        end
    endgenerate

    assign end_vec[PATTERN_MAX] = used_vec[PATTERN_MAX-1];
    assign pre_vec[PATTERN_MAX] = fwd_vec[PATTERN_MAX-1];
    assign star_vec             = {1'b0, star_cells};
    assign start_vec            = {r_start_end, start_cells};

    wnm_closure #(
        .W (NPOS)
    ) u_closure (
        .i_set  (pre_vec),
        .i_star (star_vec),
        .o_set  (closed_vec)
    );

    assign res_valid = (is_name & i_in_word.last) | is_query;
    assign res.matched = is_query ? |(start_vec & end_vec) : |(closed_vec & end_vec);
    assign res.pattern_overflow = r_ovf;

    always_comb begin
        n_busy      = r_busy;
        n_ovf       = r_ovf;
        n_start_end = r_start_end;
        if (is_clear) begin
            n_busy      = 1'b0;
            n_ovf       = 1'b0;
            n_start_end = 1'b0;
        end else if (is_append) begin
            n_busy      = 1'b0;
            n_ovf       = r_ovf | used_vec[PATTERN_MAX-1];
            n_start_end = r_start_end | ext_chain[PATTERN_MAX];
        end else if (is_query) begin
            n_busy = 1'b0;
        end else if (is_name) begin
            n_busy = ~i_in_word.last;
        end
    end

    // output register with a skid word behind it
    assign out_fire = r_out_valid & ~i_out_stall;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        n_skid_valid = r_skid_valid;
        n_skid       = r_skid;
        if (r_skid_valid) begin
            if (out_fire) begin
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid_valid = 1'b0;
            end
        end else if (r_out_valid & ~out_fire) begin
            if (res_valid) begin
                n_skid       = res;
                n_skid_valid = 1'b1;
            end
        end else begin
            n_out       = res;
            n_out_valid = res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b0;
            r_ovf        <= 1'b0;
            r_start_end  <= 1'b0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_busy       <= n_busy;
            r_ovf        <= n_ovf;
            r_start_end  <= n_start_end;
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

`ifndef NO_ASSERTIONS
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid word held without an output word");

    a_ovf_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> used_vec[PATTERN_MAX-1])
        else $error("overflow flag set while pattern not full");

    a_query_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        is_query |=> r_out_valid)
        else $error("empty name query produced no result");
`endif

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for wildcard_name_matcher_unit: directed words, then random
// pattern and name sequences, each checked against a typed expectation or an in-bench
// glob predictor. Depends on wnm_pkg and the matcher RTL only.
module testbench;
    import wnm_pkg::*;

    localparam int PMAX        = PATTERN_MAX_DEF;
    localparam int ITEMS       = 850;
    localparam int TAIL        = 100;
    localparam int STUCK_LIMIT = 200;
    localparam int DIR_N       = 24;
    localparam int IN_W        = $bits(t_in_word);
    localparam logic [PMAX:0] START_SET = {{PMAX{1'b0}}, 1'b1};

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [CHAR_W-1:0] ch;
        logic              lst;
        logic              typed;
        logic              matched;
        logic              ovf;
    } t_dir_row;

    typedef struct packed {
        t_in_word  w;
        logic      typed;
        t_out_word want;
        logic      drain;
    } t_plan_word;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_word  i_in_word   = '0;
    logic      i_out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_word o_out_word;

    // Directed words: expectations typed in only where obvious, the rest predicted
    t_dir_row dir_rows [0:DIR_N-1] = '{
        '{CMD_QUERY,  8'h00,     1'b1, 1'b1, 1'b1, 1'b0}, // empty pattern, empty name
        '{CMD_NAME,   8'h61,     1'b1, 1'b1, 1'b0, 1'b0}, // empty pattern, one char
        '{CMD_APPEND, STAR_CHAR, 1'b1, 1'b0, 1'b0, 1'b0},
        '{CMD_QUERY,  8'h00,     1'b0, 1'b1, 1'b1, 1'b0}, // star takes the empty name
        '{CMD_NAME,   8'h00,     1'b1, 1'b1, 1'b1, 1'b0},
        '{CMD_NAME,   8'hff,     1'b0, 1'b0, 1'b0, 1'b0},
        '{CMD_NAME,   8'h41,     1'b1, 1'b1, 1'b1, 1'b0},
        '{CMD_APPEND, ANY_CHAR,  1'b0, 1'b0, 1'b0, 1'b0},
        '{CMD_QUERY,  8'hff,     1'b1, 1'b1, 1'b0, 1'b0}, // '?' needs a char
        '{CMD_NAME,   8'hff,     1'b1, 1'b0, 1'b0, 1'b0},
        '{CMD_CLEAR,  8'hff,     1'b1, 1'b0, 1'b0, 1'b0},
        '{CMD_APPEND, 8'h00,     1'b0, 1'b0, 1'b0, 1'b0},
        '{CMD_APPEND, 8'hff,     1'b1, 1'b0, 1'b0, 1'b0},
        '{CMD_NAME,   8'h00,     1'b0, 1'b0, 1'b0, 1'b0},
        '{CMD_NAME,   8'hff,     1'b1, 1'b0, 1'b0, 1'b0},
        '{CMD_NAME,   8'h00,     1'b0, 1'b0, 1'b0, 1'b0}, // abandoned by the append
        '{CMD_APPEND, STAR_CHAR, 1'b0, 1'b0, 1'b0, 1'b0},
        '{CMD_NAME,   8'hff,     1'b1, 1'b0, 1'b0, 1'b0},
        '{CMD_NAME,   8'h00,     1'b0, 1'b0, 1'b0, 1'b0},
        '{CMD_NAME,   8'hff,     1'b0, 1'b0, 1'b0, 1'b0},
        '{CMD_QUERY,  8'h2a,     1'b0, 1'b0, 1'b0, 1'b0}, // drops the name in progress
        '{CMD_NAME,   8'h00,     1'b0, 1'b0, 1'b0, 1'b0},
        '{CMD_CLEAR,  8'h00,     1'b0, 1'b0, 1'b0, 1'b0},
        '{CMD_QUERY,  8'h00,     1'b1, 1'b1, 1'b1, 1'b0}
    };

    t_plan_word  word_plan [$];
    t_out_word   verdict_q [$];
    logic [7:0]  plan_pat [$];
    logic [7:0]  plan_name [$];
    logic        mid_drain_set = 1'b0;
    int          err_count = 0;
    int          stuck_cycles = 0;
    int          hold_left = 0;
    logic [7:0]  beat = '0;
    logic        quiet_tail = 1'b0;

    // predictor state
    logic [7:0]    pat_mem [PMAX];
    int            pat_len = 0;
    logic [PMAX:0] reach = '0;
    logic          in_name = 1'b0;
    logic          ovf_seen = 1'b0;

    wildcard_name_matcher_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    always #1 i_clk = ~i_clk;

    // Let a star at a reached position be skipped
    function automatic logic [PMAX:0] close_stars(logic [PMAX:0] s);
        for (int k = 0; k < pat_len; k++) begin
            if (s[k] && pat_mem[k] == STAR_CHAR) s[k+1] = 1'b1;
        end
        return s;
    endfunction

    task automatic glob_predict(input t_in_word w, output logic gives, output t_out_word res);
        logic [PMAX:0] nxt;
        gives = 1'b0;
        res   = '0;
        case (w.cmd)
            CMD_CLEAR: begin
                pat_len  = 0;
                ovf_seen = 1'b0;
                in_name  = 1'b0;
                reach    = '0;
            end
            CMD_APPEND: begin
                in_name = 1'b0;
                if (pat_len < PMAX) begin
                    pat_mem[pat_len] = w.char_value;
                    pat_len++;
                end else begin
                    ovf_seen = 1'b1;
                end
            end
            CMD_NAME: begin
                if (!in_name) begin
                    reach   = close_stars(START_SET);
                    in_name = 1'b1;
                end
                nxt = '0;
                for (int k = 0; k < pat_len; k++) begin
                    if (reach[k]) begin
                        if (pat_mem[k] == STAR_CHAR) nxt[k] = 1'b1;
                        else if (pat_mem[k] == ANY_CHAR || pat_mem[k] == w.char_value)
                            nxt[k+1] = 1'b1;
                    end
                end
                reach = close_stars(nxt);
                if (w.last) begin
                    in_name              = 1'b0;
                    gives                = 1'b1;
                    res.matched          = reach[pat_len];
                    res.pattern_overflow = ovf_seen;
                end
            end
            CMD_QUERY: begin
                in_name              = 1'b0;
                reach                = close_stars(START_SET);
                gives                = 1'b1;
                res.matched          = reach[pat_len];
                res.pattern_overflow = ovf_seen;
            end
        endcase
    endtask

    task automatic add_word(logic [CMD_W-1:0] c, logic [7:0] ch, logic lst, logic drain);
        t_plan_word p;
        p       = '0;
        p.w     = '{cmd: c, char_value: ch, last: lst};
        p.drain = drain;
        word_plan.push_back(p);
    endtask

    function automatic logic [7:0] pick_pat_char();
        case ($urandom_range(0, 9))
            0, 1:    return STAR_CHAR;
            2:       return ANY_CHAR;
            3:       return 8'($urandom_range(0, 255));
            default: return 8'h61 + 8'($urandom_range(0, 2));
        endcase
    endfunction

    function automatic logic [7:0] pick_name_char();
        case ($urandom_range(0, 11))
            0:       return 8'($urandom_range(0, 255));
            1:       return STAR_CHAR;
            2:       return ANY_CHAR;
            default: return 8'h61 + 8'($urandom_range(0, 2));
        endcase
    endfunction

    // Mostly names that fit the pattern, some mutated, some free-form
    task automatic make_name();
        plan_name.delete();
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 8)) plan_name.push_back(pick_name_char());
        end else begin
            foreach (plan_pat[k]) begin
                if (plan_pat[k] == STAR_CHAR)
                    repeat ($urandom_range(0, 3)) plan_name.push_back(pick_name_char());
                else if (plan_pat[k] == ANY_CHAR) plan_name.push_back(pick_name_char());
                else plan_name.push_back(plan_pat[k]);
            end
            if (plan_name.size() > 0 && $urandom_range(0, 2) == 0)
                plan_name[$urandom_range(0, plan_name.size() - 1)] = pick_name_char();
        end
    endtask

    task automatic plan_words();
        t_plan_word p;
        logic [7:0] ch;
        int         plen;
        int         scen;
        scen = 0;
        foreach (dir_rows[r]) begin
            p                      = '0;
            p.w                    = '{cmd: dir_rows[r].cmd, char_value: dir_rows[r].ch,
                                       last: dir_rows[r].lst};
            p.typed                = dir_rows[r].typed;
            p.want.matched         = dir_rows[r].matched;
            p.want.pattern_overflow = dir_rows[r].ovf;
            word_plan.push_back(p);
        end
        while (word_plan.size() < DIR_N + ITEMS) begin
            if (scen == 0) plen = PMAX + 2;
            else if (scen == 1) plen = PMAX;
            else if ($urandom_range(0, 19) == 0) plen = $urandom_range(PMAX - 4, PMAX + 6);
            else plen = $urandom_range(0, 8);
            // hold the sender until all results are in, once early and once midway
            add_word(CMD_CLEAR, 8'($urandom), 1'($urandom),
                     scen == 0 || (!mid_drain_set && word_plan.size() >= 450));
            if (word_plan.size() >= 450) mid_drain_set = 1'b1;
            plan_pat.delete();
            for (int k = 0; k < plen; k++) begin
                ch = (scen == 0) ? STAR_CHAR : pick_pat_char();
                if (plan_pat.size() < PMAX) plan_pat.push_back(ch);
                add_word(CMD_APPEND, ch, 1'($urandom), 1'b0);
            end
            repeat ($urandom_range(1, 6)) begin
                case ($urandom_range(0, 9))
                    0: add_word(CMD_QUERY, 8'($urandom), 1'($urandom), 1'b0);
                    1: begin
                        // broken name: cut short by an append, a query or a clear
                        repeat ($urandom_range(1, 4))
                            add_word(CMD_NAME, pick_name_char(), 1'b0, 1'b0);
                        case ($urandom_range(0, 2))
                            0: begin
                                ch = pick_pat_char();
                                if (plan_pat.size() < PMAX) plan_pat.push_back(ch);
                                add_word(CMD_APPEND, ch, 1'($urandom), 1'b0);
                            end
                            1: add_word(CMD_QUERY, 8'($urandom), 1'($urandom), 1'b0);
                            default: begin
                                plan_pat.delete();
                                add_word(CMD_CLEAR, 8'($urandom), 1'($urandom), 1'b0);
                            end
                        endcase
                    end
                    default: begin
                        make_name();
                        if (plan_name.size() == 0)
                            add_word(CMD_QUERY, 8'($urandom), 1'($urandom), 1'b0);
                        foreach (plan_name[k])
                            add_word(CMD_NAME, plan_name[k], k == plan_name.size() - 1, 1'b0);
                    end
                endcase
            end
            scen++;
        end
    endtask

    task automatic report_mismatch(string msg);
        $display("%0t: mismatch: %s", $time, msg);
        err_count++;
    endtask

    // Result stall: random bursts, with the stall released between bursts
    always @(posedge i_clk) begin
        beat <= beat + 8'd1;
        if (!i_rst_n || quiet_tail || beat[7]) begin
            i_out_stall <= 1'b0;
            hold_left   <= 0;
        end else if (hold_left != 0) begin
            i_out_stall <= 1'b1;
            hold_left   <= hold_left - 1;
        end else if (!i_out_stall && $urandom_range(0, 7) == 0) begin
            i_out_stall <= 1'b1;
            hold_left   <= $urandom_range(0, 9);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (verdict_q.size() == 0) begin
                report_mismatch($sformatf("result %b with nothing due", o_out_word));
            end else begin
                want = verdict_q.pop_front();
                if (o_out_word.matched !== want.matched)
                    report_mismatch($sformatf("matched got %b want %b",
                                              o_out_word.matched, want.matched));
                if (o_out_word.pattern_overflow !== want.pattern_overflow)
                    report_mismatch($sformatf("pattern_overflow got %b want %b",
                                              o_out_word.pattern_overflow,
                                              want.pattern_overflow));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    initial begin : watchdog
        wait (stuck_cycles >= STUCK_LIMIT);
        $display("testbench: FAIL");
        $finish;
    end

    initial begin : sender
        t_plan_word p;
        t_out_word  res;
        logic       gives;
        logic       tail;
        plan_words();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int n = 0; n < word_plan.size(); n++) begin
            p    = word_plan[n];
            tail = (n >= word_plan.size() - TAIL);
            quiet_tail <= tail;
            if (p.drain) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
                while (verdict_q.size() != 0) @(posedge i_clk);
            end else if (!tail && (n % 64) < 40 && $urandom_range(0, 5) == 0) begin
                i_in_valid <= 1'b0;
                i_in_word  <= IN_W'($urandom_range(0, 2047));
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
            end
            i_in_valid <= 1'b1;
            i_in_word  <= p.w;
            @(posedge i_clk);
            while (o_in_stall) @(posedge i_clk);
            glob_predict(p.w, gives, res);
            if (gives) verdict_q.push_back(p.typed ? p.want : res);
        end
        i_in_valid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (err_count == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

FILE: files.f
rtl/wnm_pkg.sv
rtl/wnm_cell.sv
rtl/wnm_closure.sv
rtl/wildcard_name_matcher_unit.sv
tb/testbench.sv
